// ===== rtl/core/sida_pkg.sv =====
// Package for the slot ID allocator: operation and status codes, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package sida_pkg;

  localparam int unsigned SlotsDef = 64;
  localparam int unsigned IdW      = 6;

  typedef enum logic [1:0] {
    OpAlloc  = 2'd0,
    OpFree   = 2'd1,
    OpLookup = 2'd2,
    OpClear  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StReject = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CtlIdle,
    CtlExec,
    CtlPop
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the request fields
    logic exec;      // carry out the captured operation
    logic pop_rd;    // read the top of the free stack
    logic pop_done;  // finish an allocate from the free stack
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_pop;  // captured request is an allocate served by the stack
  } stat_t;

endpackage

// ===== rtl/core/sida_ctrl.sv =====
// Controller state machine of the slot ID allocator.
// Depends on sida_pkg; drives the datapath commands and the handshakes.
`timescale 1ns / 1ps

module sida_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  sida_pkg::stat_t stat_i,
  output sida_pkg::cmd_t  cmd_o
);
  import sida_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CtlIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      CtlIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = CtlExec;
        end
      end
      CtlExec: begin
        // The result register must be free before the operation commits.
        if (out_free) begin
          cmd_o.exec = 1'b1;
          if (stat_i.need_pop) begin
            cmd_o.pop_rd = 1'b1;
            state_d      = CtlPop;
          end else begin
            state_d = CtlIdle;
          end
        end
      end
      CtlPop: begin
        cmd_o.pop_done = 1'b1;
        state_d        = CtlIdle;
      end
      default: state_d = CtlIdle;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i)
                     || (cmd_o.exec && !stat_i.need_pop)
                     || cmd_o.pop_done;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/sida_dp.sv =====
// Datapath of the slot ID allocator: high-water mark, free stack memory,
// freed marks, request capture and result register. Depends on sida_pkg.
`timescale 1ns / 1ps

module sida_dp #(
  parameter int unsigned SLOTS = sida_pkg::SlotsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sida_pkg::cmd_t            cmd_i,
  input  logic [1:0]                op_i,
  input  logic [sida_pkg::IdW-1:0]  id_i,
  output sida_pkg::stat_t           stat_o,
  output logic [sida_pkg::IdW-1:0]  res_id_o,
  output logic [1:0]                res_status_o
);
  import sida_pkg::*;

  // Only slot numbers that fit the ID field can ever be freed, so the stack
  // and the marks need no more entries than that.
  localparam int unsigned MarkDepth = (SLOTS < (1 << IdW)) ? SLOTS : (1 << IdW);
  localparam int unsigned MarkIdxW  = $clog2(MarkDepth);
  localparam int unsigned CntW      = $clog2(MarkDepth + 1);
  localparam int unsigned HwW       = $clog2(SLOTS + 1);
  localparam int unsigned CmpW      = (HwW > IdW) ? HwW : IdW;

  op_e                  op_q;
  logic [IdW-1:0]       id_q;
  logic [HwW-1:0]       hw_q, hw_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [MarkDepth-1:0] marks_q, marks_d;
  logic [IdW-1:0]       mem [MarkDepth];
  logic [IdW-1:0]       rd_data_q;
  logic [IdW-1:0]       res_id_q, res_id_d;
  status_e              res_st_q, res_st_d;

  logic                 live;
  logic                 push_en;
  logic                 res_load;
  logic [MarkIdxW-1:0]  id_idx;
  logic [MarkIdxW-1:0]  push_addr;
  logic [MarkIdxW-1:0]  pop_addr;

  assign id_idx    = id_q[MarkIdxW-1:0];
  assign push_addr = cnt_q[MarkIdxW-1:0];
  assign pop_addr  = MarkIdxW'(cnt_q - 1'b1);

  // A slot is live when it was issued and is not sitting on the free stack.
  assign live = (CmpW'(id_q) < CmpW'(hw_q)) && !marks_q[id_idx];

  assign stat_o.need_pop = (op_q == OpAlloc) && (cnt_q != '0);

  always_comb begin
    hw_d     = hw_q;
    cnt_d    = cnt_q;
    marks_d  = marks_q;
    push_en  = 1'b0;
    res_id_d = id_q;
    res_st_d = StOk;
    if (cmd_i.exec) begin
      case (op_q)
        OpAlloc: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
          end else if (CmpW'(hw_q) < CmpW'(SLOTS)) begin
            res_id_d = IdW'(hw_q);
            hw_d     = hw_q + 1'b1;
          end else begin
            res_st_d = StFull;
          end
        end
        OpFree: begin
          if (live && (cnt_q < CntW'(MarkDepth))) begin
            marks_d[id_idx] = 1'b1;
            push_en         = 1'b1;
            cnt_d           = cnt_q + 1'b1;
          end else begin
            res_st_d = StReject;
          end
        end
        OpLookup: res_st_d = live ? StOk : StReject;
        OpClear: begin
          hw_d    = '0;
          cnt_d   = '0;
          marks_d = '0;
        end
        default: res_st_d = StOk;
      endcase
    end
    if (cmd_i.pop_done) begin
      marks_d[rd_data_q[MarkIdxW-1:0]] = 1'b0;
      res_id_d = rd_data_q;
      res_st_d = StOk;
    end
  end

  assign res_load = (cmd_i.exec && !stat_o.need_pop) || cmd_i.pop_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q    <= '0;
      cnt_q   <= '0;
      marks_q <= '0;
    end else begin
      hw_q    <= hw_d;
      cnt_q   <= cnt_d;
      marks_q <= marks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q <= op_e'(op_i);
      id_q <= id_i;
    end
    if (res_load) begin
      res_id_q <= res_id_d;
      res_st_q <= res_st_d;
    end
  end

  // Free stack memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem[push_addr] <= id_q;
    end
    if (cmd_i.pop_rd) begin
      rd_data_q <= mem[pop_addr];
    end
  end

  assign res_id_o     = res_id_q;
  assign res_status_o = res_st_q;

  // Every stacked slot carries exactly one freed mark. While a pop finishes,
  // the depth has already dropped but the popped slot still holds its mark.
  a_marks_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(marks_q) == int'(cnt_q) + int'(cmd_i.pop_done))
    else $error("freed marks disagree with free stack depth");

  // Only issued slots can be on the free stack.
  a_count_below_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(cnt_q) <= CmpW'(hw_q))
    else $error("free stack deeper than issued slots");

  // A clear empties the pool in the following cycle.
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && op_q == OpClear) |=> (cnt_q == '0 && hw_q == '0))
    else $error("clear did not empty the pool");

endmodule

// ===== rtl/core/slot_id_allocator_free_stack_top.sv =====
// Slot ID allocator top level. A request is captured in the idle state and
// executed once the result register is free; an allocate that pops the free
// stack adds a pop state for the registered read port of the stack memory.
// A new request is taken only after the previous one has been executed.
// Reset (rst_ni, asynchronous, active low) empties the pool and clears all
// freed marks at once; stack contents are left as they are.
`timescale 1ns / 1ps

module slot_id_allocator_free_stack_top #(
  parameter int unsigned SLOTS = sida_pkg::SlotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Request channel.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [5:0] slot_id, [7:6] zero
  input  logic [1:0] s_axis_tuser_i,   // [1:0] op
  // Result channel.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [5:0] slot_id_out, [7:6] zero
  output logic [1:0] m_axis_tuser_o    // [1:0] status
);
  import sida_pkg::*;

  cmd_t           cmd;
  stat_t          stat;
  logic [IdW-1:0] res_id;
  logic [1:0]     res_status;

  // The controller sequences each transaction: capture, execute, and for an
  // allocate served by the free stack a further pop state for the memory read.
  // A new request is taken while an earlier result still waits in the
  // output register; execution then holds until that register is free.
  sida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the pool state: high-water mark, free stack depth,
  // the free stack memory and one freed mark per reachable slot.
  sida_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (s_axis_tuser_i),
    .id_i         (s_axis_tdata_i[IdW-1:0]),
    .stat_o       (stat),
    .res_id_o     (res_id),
    .res_status_o (res_status)
  );

  assign m_axis_tdata_o = {{(8 - IdW){1'b0}}, res_id};
  assign m_axis_tuser_o = res_status;

endmodule

// ===== verif/slot_id_allocator_free_stack_top_tb.sv =====
// Self-checking testbench for the slot ID allocator top level: a directed
// table and random requests, checked against an in-bench pool predictor.
// Depends on sida_pkg and slot_id_allocator_free_stack_top.
`timescale 1ns / 1ps

module slot_id_allocator_free_stack_top_tb;

  import sida_pkg::*;

  localparam int unsigned SLOTS            = SlotsDef;
  localparam int unsigned HALF_PERIOD      = 6;
  localparam int unsigned RESET_CYCLES     = 6;
  localparam int unsigned RANDOM_PER_PHASE = 341;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned NUM_ROWS         = 24;

  // One expected result transaction: granted or echoed slot plus status.
  typedef struct packed {
    logic [IdW-1:0] slot;
    status_e        status;
  } grant_t;

  // One row of the directed table. A row with has_want set carries its
  // expected result typed in; other rows are checked against the predictor.
  typedef struct packed {
    op_e            op;
    logic [IdW-1:0] slot;
    int             reps;
    bit             has_want;
    logic [IdW-1:0] want_slot;
    status_e        want_status;
  } script_row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           s_axis_tvalid_i;
  logic           s_axis_tready_o;
  logic [7:0]     s_axis_tdata_i;   // [5:0] slot_id, [7:6] zero
  logic [1:0]     s_axis_tuser_i;   // [1:0] op
  logic           m_axis_tvalid_o;
  logic           m_axis_tready_i;
  logic [7:0]     m_axis_tdata_o;   // [5:0] slot_id_out, [7:6] zero
  logic [1:0]     m_axis_tuser_o;   // [1:0] status

  // Predictor copy of the pool. All of it starts at zero, which matches the
  // state right after reset; stack entries are only read after being pushed.
  bit [6:0]       issued_count;
  bit [6:0]       stack_depth;
  bit [IdW-1:0]   freed_stack [SLOTS];
  bit             freed_flag [SLOTS];

  grant_t         pending_grants [$];
  int unsigned    error_count;
  int unsigned    stall_pct;   // chance in percent that the sink holds off

  // Directed table: lookups and frees on an empty pool, allocation from the
  // never-used range, double free, LIFO reuse from the free stack, clear,
  // filling the pool to the full condition and reuse at the top slot numbers.
  script_row_t script [NUM_ROWS] = '{
    '{OpLookup, 6'd0,  1,  1'b1, 6'd0,  StReject},
    '{OpFree,   6'd63, 1,  1'b1, 6'd63, StReject},
    '{OpAlloc,  6'd21, 1,  1'b1, 6'd0,  StOk},
    '{OpAlloc,  6'd42, 1,  1'b1, 6'd1,  StOk},
    '{OpLookup, 6'd1,  1,  1'b1, 6'd1,  StOk},
    '{OpFree,   6'd0,  1,  1'b1, 6'd0,  StOk},
    '{OpFree,   6'd0,  1,  1'b1, 6'd0,  StReject},
    '{OpLookup, 6'd0,  1,  1'b1, 6'd0,  StReject},
    '{OpAlloc,  6'd63, 1,  1'b1, 6'd0,  StOk},
    '{OpFree,   6'd1,  1,  1'b1, 6'd1,  StOk},
    '{OpFree,   6'd0,  1,  1'b1, 6'd0,  StOk},
    '{OpAlloc,  6'd0,  1,  1'b1, 6'd0,  StOk},
    '{OpAlloc,  6'd0,  1,  1'b1, 6'd1,  StOk},
    '{OpClear,  6'd45, 1,  1'b1, 6'd45, StOk},
    '{OpLookup, 6'd0,  1,  1'b1, 6'd0,  StReject},
    '{OpAlloc,  6'd0,  64, 1'b0, 6'd0,  StOk},
    '{OpAlloc,  6'd42, 1,  1'b1, 6'd42, StFull},
    '{OpLookup, 6'd63, 1,  1'b1, 6'd63, StOk},
    '{OpFree,   6'd63, 1,  1'b1, 6'd63, StOk},
    '{OpFree,   6'd62, 1,  1'b1, 6'd62, StOk},
    '{OpAlloc,  6'd5,  1,  1'b1, 6'd62, StOk},
    '{OpAlloc,  6'd5,  1,  1'b1, 6'd63, StOk},
    '{OpAlloc,  6'd0,  1,  1'b1, 6'd0,  StFull},
    '{OpClear,  6'd0,  1,  1'b1, 6'd0,  StOk}
  };

  slot_id_allocator_free_stack_top #(
    .SLOTS (SLOTS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // A slot is live while it has been issued since the last clear and is not
  // sitting on the free stack.
  function automatic bit slot_is_live(logic [IdW-1:0] id);
    return (id < issued_count) && !freed_flag[id];
  endfunction

  // Applies one request to the predictor pool and returns its result.
  function automatic grant_t predict_grant(op_e op, logic [IdW-1:0] id);
    grant_t g;
    g.slot   = id;
    g.status = StOk;
    case (op)
      OpAlloc: begin
        // The most recently freed slot wins over a never-used one.
        if (stack_depth != 0) begin
          stack_depth--;
          g.slot = freed_stack[stack_depth[IdW-1:0]];
          freed_flag[g.slot] = 1'b0;
        end else if (issued_count < SLOTS) begin
          g.slot = issued_count[IdW-1:0];
          issued_count++;
        end else begin
          g.status = StFull;
        end
      end
      OpFree: begin
        if (slot_is_live(id) && stack_depth < SLOTS) begin
          freed_flag[id] = 1'b1;
          freed_stack[stack_depth[IdW-1:0]] = id;
          stack_depth++;
        end else begin
          g.status = StReject;
        end
      end
      OpLookup: begin
        g.status = slot_is_live(id) ? StOk : StReject;
      end
      default: begin
        issued_count = '0;
        stack_depth  = '0;
        foreach (freed_flag[i]) freed_flag[i] = 1'b0;
      end
    endcase
    return g;
  endfunction

  // Picks a live slot if one exists, scanning from a random start so that
  // any live slot can be chosen; falls back to any slot number.
  function automatic logic [IdW-1:0] pick_live_slot();
    logic [IdW-1:0] start;
    logic [IdW-1:0] id;
    start = IdW'($urandom);
    for (int k = 0; k < SLOTS; k++) begin
      id = start + IdW'(k);
      if (slot_is_live(id)) return id;
    end
    return start;
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $time, msg);
  endfunction

  // Presents one request and holds it until the allocator takes it. The
  // prediction is made at the accepting edge, so request order is kept.
  // Valid stays high on return; the caller lowers it only for a gap.
  task automatic send_request(op_e op, logic [IdW-1:0] id, bit has_want, grant_t want);
    grant_t g;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, id};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    g = predict_grant(op, id);
    pending_grants.push_back(has_want ? want : g);
  endtask

  // Sink side: random back-pressure at the rate the current phase asks for.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Result checker: every accepted result transaction is matched, field by
  // field, against the oldest outstanding expectation.
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_grants.size() == 0) begin
        note_error($sformatf("unexpected result slot=%0d status=%0d",
                             m_axis_tdata_o[IdW-1:0], m_axis_tuser_o));
      end else begin
        want = pending_grants.pop_front();
        if (m_axis_tdata_o[IdW-1:0] !== want.slot || m_axis_tuser_o !== want.status) begin
          note_error($sformatf({"result mismatch: expected slot=%0d status=%0d, ",
                                "got slot=%0d status=%0d"},
                               want.slot, want.status, m_axis_tdata_o[IdW-1:0],
                               m_axis_tuser_o));
        end
      end
    end
  end

  // Main sequence: reset, directed table, then four random phases that vary
  // the idling on both sides of the allocator.
  initial begin
    int unsigned send_gap_pct;
    int unsigned pick;
    op_e         op;
    logic [IdW-1:0] id;

    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OpAlloc;
    m_axis_tready_i = 1'b0;
    stall_pct       = 0;
    error_count     = 0;
    send_gap_pct    = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, back to back with the sink always ready.
    foreach (script[r]) begin
      for (int k = 0; k < script[r].reps; k++) begin
        send_request(script[r].op, script[r].slot, script[r].has_want,
                     '{script[r].want_slot, script[r].want_status});
      end
    end

    // Random phases. Allocates outnumber frees, so the pool drifts toward
    // full between the rare clears; most frees and half the lookups target
    // live slots so that requests reach past the reject paths.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          send_gap_pct = 67;
          stall_pct    = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 67;
        end
        default: begin
          send_gap_pct = 29;
          stall_pct    = 29;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        while ($urandom_range(0, 99) < send_gap_pct) begin
          s_axis_tvalid_i <= 1'b0;
          @(posedge clk_i);
        end
        pick = $urandom_range(0, 299);
        id   = IdW'($urandom);
        if (pick == 0) begin
          op = OpClear;
        end else if (pick < 150) begin
          op = OpAlloc;
        end else if (pick < 240) begin
          op = OpFree;
          if ($urandom_range(0, 3) != 0) id = pick_live_slot();
        end else begin
          op = OpLookup;
          if ($urandom_range(0, 1) != 0) id = pick_live_slot();
        end
        send_request(op, id, 1'b0, '0);
      end
    end

    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_grants.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run under full idling.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
